// ===== rtl/tlsrd_pkg.sv =====
// tlsrd_pkg: types and constants for the tls 1.3 record deframer
// no dependencies; imported by tls13_record_deframer
package tlsrd_pkg;

   typedef enum logic [2:0] {
      PH_TYPE   = 3'd0,
      PH_VER_HI = 3'd1,
      PH_VER_LO = 3'd2,
      PH_LEN_HI = 3'd3,
      PH_LEN_LO = 3'd4,
      PH_BODY   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BODY  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_ZERO_LEN  = 3'd1,
      ERR_TOO_LONG  = 3'd2,
      ERR_ALERT     = 3'd3,
      ERR_BAD_CCS   = 3'd4,
      ERR_SEQ_EXH   = 3'd5
   } err_type;

   localparam logic [7:0]  TYPE_CCS    = 8'd20;
   localparam logic [7:0]  TYPE_ALERT  = 8'd21;
   localparam logic [7:0]  CCS_BODY    = 8'h01;
   localparam logic [15:0] LIMIT_RESET = 16'h4000 + 16'd256;
   localparam logic [15:0] ALERT_LEN   = 16'd2;
   localparam logic [15:0] CCS_LEN     = 16'd1;

   localparam int RSP_DATA_W = 120;

endpackage

// ===== rtl/tls13_record_deframer.sv =====
// tls13_record_deframer: byte-wise tls 1.3 record header parser and body splitter
// depends on tlsrd_pkg
//
//   channel | dir | payload                                         | handshake
//   req     | in  | tdata: data_byte                                | tvalid/tready
//   rsp     | out | tdata: header, sequence, error; tuser: kind     | tvalid/tready/tlast
//   csr     | in  | max_record_length                               | write enable
//
// one byte per cycle while ready is high; each request's result, if any, is
// written to the result register. ready follows the result register: a new request
// is taken whenever that register is empty or drained in the same cycle.
// synchronous reset returns to the type byte with sequence zero, limit 16640.
// after any error all later requests are consumed with no result until reset.
module tls13_record_deframer
   import tlsrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // body_byte, record_type, record_version,
                                              // record_length, sequence_number,
                                              // error_code, zero pad
   output logic [1:0]            rsp_tuser,   // [1:0] kind
   output logic                  rsp_tlast,   // is_last
   input  logic                  csr_we,
   input  logic [15:0]           csr_wdata    // max_record_length
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] ver_ff, ver_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  first_ff, first_in;
   logic [63:0] seq_ff, seq_in;
   logic        failed_ff, failed_in;
   logic [15:0] limit_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff;
   logic [7:0]  rsp_body_ff;
   logic [7:0]  rsp_type_ff;
   logic [15:0] rsp_ver_ff;
   logic [15:0] rsp_len_ff;
   logic [63:0] rsp_seq_ff;
   logic        rsp_last_ff;
   logic [2:0]  rsp_code_ff;

   logic        accept;
   logic        res_valid;
   kind_type    res_kind;
   logic [7:0]  res_body;
   logic        res_last;
   err_type     res_code;

   logic [7:0]  b;
   logic        special_cur;
   logic        special_new;
   logic [15:0] len_new;
   logic [15:0] left_dec;
   logic        body_last;
   logic [7:0]  first_cur;

   assign b          = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign len_new     = {len_ff[15:8], b};
   assign special_cur = (type_ff == TYPE_CCS) || (type_ff == TYPE_ALERT && len_ff == ALERT_LEN);
   assign special_new = (type_ff == TYPE_CCS) || (type_ff == TYPE_ALERT && len_new == ALERT_LEN);
   assign left_dec    = left_ff - 16'd1;
   assign body_last   = (left_dec == 16'd0);
   assign first_cur   = (left_ff == len_ff) ? b : first_ff;

   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      ver_in    = ver_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      first_in  = first_ff;
      seq_in    = seq_ff;
      failed_in = failed_ff;
      res_valid = 1'b0;
      res_kind  = KIND_START;
      res_body  = 8'd0;
      res_last  = 1'b0;
      res_code  = ERR_NONE;
      if (accept && !failed_ff) begin
         case (phase_ff)
            PH_TYPE: begin
               type_in  = b;
               phase_in = PH_VER_HI;
            end
            PH_VER_HI: begin
               ver_in   = {b, 8'd0};
               phase_in = PH_VER_LO;
            end
            PH_VER_LO: begin
               ver_in   = {ver_ff[15:8], b};
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len_in   = {b, 8'd0};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len_in = len_new;
               if (len_new == 16'd0) begin
                  failed_in = 1'b1;
                  res_valid = 1'b1;
                  res_kind  = KIND_ERROR;
                  res_code  = ERR_ZERO_LEN;
               end else if (len_new > limit_ff) begin
                  failed_in = 1'b1;
                  res_valid = 1'b1;
                  res_kind  = KIND_ERROR;
                  res_code  = ERR_TOO_LONG;
               end else begin
                  left_in  = len_new;
                  phase_in = PH_BODY;
                  if (!special_new) begin
                     res_valid = 1'b1;
                     if (seq_ff == '1) begin
                        failed_in = 1'b1;
                        res_kind  = KIND_ERROR;
                        res_code  = ERR_SEQ_EXH;
                     end else begin
                        res_kind = KIND_START;
                     end
                  end
               end
            end
            default: begin
               first_in = first_cur;
               left_in  = left_dec;
               if (body_last) begin
                  phase_in = PH_TYPE;
               end
               if (special_cur) begin
                  if (body_last) begin
                     if (type_ff == TYPE_CCS) begin
                        if (!(len_ff == CCS_LEN && first_cur == CCS_BODY)) begin
                           failed_in = 1'b1;
                           res_valid = 1'b1;
                           res_kind  = KIND_ERROR;
                           res_code  = ERR_BAD_CCS;
                        end
                     end else begin
                        failed_in = 1'b1;
                        res_valid = 1'b1;
                        res_kind  = KIND_ERROR;
                        res_body  = b;
                        res_code  = ERR_ALERT;
                     end
                  end
               end else begin
                  res_valid = 1'b1;
                  res_kind  = KIND_BODY;
                  res_body  = b;
                  res_last  = body_last;
                  if (body_last) begin
                     seq_in = seq_ff + 64'd1;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         type_ff      <= 8'd0;
         ver_ff       <= 16'd0;
         len_ff       <= 16'd0;
         left_ff      <= 16'd0;
         first_ff     <= 8'd0;
         seq_ff       <= 64'd0;
         failed_ff    <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         type_ff      <= type_in;
         ver_ff       <= ver_in;
         len_ff       <= len_in;
         left_ff      <= left_in;
         first_ff     <= first_in;
         seq_ff       <= seq_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_kind_ff <= res_kind;
         rsp_body_ff <= res_body;
         rsp_type_ff <= type_in;
         rsp_ver_ff  <= ver_in;
         rsp_len_ff  <= len_in;
         rsp_seq_ff  <= seq_ff;
         rsp_last_ff <= res_last;
         rsp_code_ff <= res_code;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_code_ff, rsp_seq_ff, rsp_len_ff, rsp_ver_ff,
                        rsp_type_ff, rsp_body_ff};

endmodule

// ===== sim/tls13_record_deframer_tb.sv =====
// tls13_record_deframer_tb: self-checking bench for the tls 1.3 record deframer
// depends on tlsrd_pkg and tls13_record_deframer; a scoreboard class predicts results
// from the byte stream, plain tasks drive records, limit writes and stalls
`timescale 1ns / 1ps

module tls13_record_deframer_tb
   import tlsrd_pkg::*;
();

   localparam logic [7:0]  APP_DATA      = 8'd23;
   localparam logic [15:0] TLS12_VERSION = 16'h0303;
   localparam int          HOLD_CYCLES   = 400;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  body;
      logic [7:0]  rtype;
      logic [15:0] version;
      logic [15:0] length;
      logic [63:0] seq;
      logic        last;
      err_type     code;
   } record_result_type;

   class deframe_scoreboard_type;
      logic [15:0]       limit = LIMIT_RESET;
      phase_type         phase = PH_TYPE;
      logic [7:0]        htype = '0;
      logic [15:0]       hver = '0;
      logic [15:0]       hlen = '0;
      logic [15:0]       left = '0;
      logic [7:0]        first_b = '0;
      logic [63:0]       seq = '0;
      logic              failed = 1'b0;
      int                fail_count = 0;
      record_result_type awaited[$];

      function void queue_result(kind_type kind, logic [7:0] body, logic last, err_type code);
         record_result_type r;
         r.kind    = kind;
         r.body    = body;
         r.rtype   = htype;
         r.version = hver;
         r.length  = hlen;
         r.seq     = seq;
         r.last    = last;
         r.code    = code;
         awaited.push_back(r);
      endfunction

      function void note_failure(logic [7:0] body, err_type code);
         failed = 1'b1;
         queue_result(KIND_ERROR, body, 1'b0, code);
      endfunction

      // accepted request: advance the parser and queue what it produces
      function void parse_byte(logic [7:0] b);
         logic special;
         logic done;
         if (failed) return;
         special = (htype == TYPE_CCS) || (htype == TYPE_ALERT && hlen == ALERT_LEN);
         case (phase)
            PH_TYPE: begin
               htype = b;
               phase = PH_VER_HI;
            end
            PH_VER_HI: begin
               hver  = {b, 8'h00};
               phase = PH_VER_LO;
            end
            PH_VER_LO: begin
               hver[7:0] = b;
               phase     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               hlen  = {b, 8'h00};
               phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               hlen[7:0] = b;
               if (hlen == 16'd0) begin
                  note_failure(8'h00, ERR_ZERO_LEN);
               end else if (hlen > limit) begin
                  note_failure(8'h00, ERR_TOO_LONG);
               end else begin
                  left  = hlen;
                  phase = PH_BODY;
                  if (!(htype == TYPE_CCS || (htype == TYPE_ALERT && hlen == ALERT_LEN))) begin
                     if (seq == '1) note_failure(8'h00, ERR_SEQ_EXH);
                     else queue_result(KIND_START, 8'h00, 1'b0, ERR_NONE);
                  end
               end
            end
            default: begin
               if (left == hlen) first_b = b;
               left = left - 16'd1;
               done = (left == 16'd0);
               if (done) phase = PH_TYPE;
               if (special) begin
                  if (done) begin
                     if (htype == TYPE_CCS) begin
                        if (!(hlen == CCS_LEN && first_b == CCS_BODY))
                           note_failure(8'h00, ERR_BAD_CCS);
                     end else begin
                        note_failure(b, ERR_ALERT);
                     end
                  end
               end else begin
                  queue_result(KIND_BODY, b, done, ERR_NONE);
                  if (done) seq = seq + 64'd1;
               end
            end
         endcase
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
         end
      endfunction

      function void compare_result(logic [RSP_DATA_W-1:0] tdata, logic [1:0] tuser,
                                   logic tlast);
         record_result_type e;
         if (awaited.size() == 0) begin
            $error("result with nothing pending: kind %0d", tuser);
            fail_count++;
            return;
         end
         e = awaited[0];
         awaited.delete(0);
         check_field("kind", 64'(e.kind), 64'(tuser));
         check_field("body_byte", 64'(e.body), 64'(tdata[7:0]));
         check_field("record_type", 64'(e.rtype), 64'(tdata[15:8]));
         check_field("record_version", 64'(e.version), 64'(tdata[31:16]));
         check_field("record_length", 64'(e.length), 64'(tdata[47:32]));
         check_field("sequence_number", e.seq, tdata[111:48]);
         check_field("error_code", 64'(e.code), 64'(tdata[114:112]));
         check_field("is_last", 64'(e.last), 64'(tlast));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [15:0]           csr_wdata = '0;

   deframe_scoreboard_type sb = new();
   int send_idle = 6;
   int recv_idle = 73;
   int bytes_sent = 0;
   int hold_left = 0;
   int hold_requests = 0;
   int hold_served = 0;

   tls13_record_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver stalls, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left   = HOLD_CYCLES;
         hold_served = hold_requests;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.compare_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99, 0) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.parse_byte(b);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [7:0] rtype, input logic [15:0] ver,
                              input logic [15:0] len);
      send_byte(rtype);
      send_byte(ver[15:8]);
      send_byte(ver[7:0]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
   endtask

   // fill below zero gives random body bytes
   task automatic send_record(input logic [7:0] rtype, input logic [15:0] ver,
                              input logic [15:0] len, input int fill);
      send_header(rtype, ver, len);
      for (int i = 0; i < len; i++)
         send_byte(fill < 0 ? 8'($urandom_range(255, 0)) : 8'(fill));
   endtask

   task automatic random_record();
      int          pick;
      int          max_len;
      logic [15:0] len;
      logic [7:0]  rtype;
      max_len = (sb.limit < 40) ? int'(sb.limit) : 40;
      pick    = $urandom_range(99, 0);
      len     = 16'($urandom_range(max_len, 1));
      if (pick < 60) begin
         send_record(APP_DATA, TLS12_VERSION, len, -1);
      end else if (pick < 72) begin
         send_record(TYPE_CCS, 16'($urandom), CCS_LEN, int'(CCS_BODY));
      end else if (pick < 84) begin
         if (len == ALERT_LEN) len = (max_len > 2) ? 16'd3 : 16'd1;
         send_record(TYPE_ALERT, 16'($urandom), len, -1);
      end else begin
         rtype = 8'($urandom_range(255, 0));
         if (rtype == TYPE_CCS || rtype == TYPE_ALERT) rtype = APP_DATA;
         send_record(rtype, 16'($urandom), len, -1);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      sb.limit = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // one sticky error ends the stream, picked at random per run
   task automatic send_fatal_record();
      err_type     pick;
      logic [15:0] len;
      logic [15:0] lim;
      int          fill;
      pick = err_type'($urandom_range(int'(ERR_BAD_CCS), int'(ERR_ZERO_LEN)));
      case (pick)
         ERR_ZERO_LEN: begin
            send_header(8'($urandom), 16'($urandom), 16'd0);
         end
         ERR_TOO_LONG: begin
            // limit of zero rejects every nonzero length
            lim = ($urandom_range(1, 0) == 0) ? 16'd0 : 16'($urandom_range(65534, 1));
            write_limit(lim);
            send_header(APP_DATA, TLS12_VERSION, 16'($urandom_range(65535, int'(lim) + 1)));
         end
         ERR_ALERT: begin
            send_record(TYPE_ALERT, 16'($urandom), ALERT_LEN, -1);
         end
         default: begin
            len  = 16'($urandom_range(4, 1));
            fill = -1;
            if (len == CCS_LEN) fill = (int'(CCS_BODY) + $urandom_range(254, 1)) % 256;
            send_record(TYPE_CCS, 16'($urandom), len, fill);
         end
      endcase
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed records at the reset limit
      send_record(APP_DATA, TLS12_VERSION, 16'd1, 0);
      send_record(8'hFF, 16'hFFFF, 16'd2, 255);
      send_record(TYPE_CCS, TLS12_VERSION, CCS_LEN, int'(CCS_BODY));
      send_record(TYPE_ALERT, 16'h0000, 16'd1, -1);
      while (bytes_sent < 350) random_record();

      send_idle = 73;
      recv_idle = 6;
      write_limit(16'd1);
      while (bytes_sent < 500) random_record();
      write_limit(16'($urandom_range(200, 2)));
      while (bytes_sent < 700) random_record();

      send_idle = 0;
      recv_idle = 0;
      write_limit(16'hFFFF);
      hold_requests++;
      while (bytes_sent < 1000) random_record();
      send_record(APP_DATA, TLS12_VERSION, 16'd48, -1);
      drain();

      send_idle = 6;
      recv_idle = 30;
      send_fatal_record();
      repeat (20) send_byte(8'($urandom));

      drain();
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0 && sb.awaited.size() == 0) begin
         $display("tls13_record_deframer_tb passed");
      end else begin
         $display("tls13_record_deframer_tb failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tls13_record_deframer_tb failed");
      $finish;
   end

endmodule
